>>> hw/rtl/evo_pkg.sv
// shared constants, state encoding and control structs for the evenodd encoder
`timescale 1ns / 1ps
`default_nettype none
package evo_pkg;

    localparam int MAX_PRIME = 17;
    localparam int ROWS_MAX  = MAX_PRIME - 1;
    localparam int IDX_W     = $clog2(ROWS_MAX);
    localparam int PRIME_W   = 5;
    localparam int COL_W     = $clog2(MAX_PRIME);
    localparam int SUM_W     = $clog2(2 * MAX_PRIME);
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(5);
    localparam logic [PRIME_W-1:0] PRIME_MIN   = PRIME_W'(3);
    localparam logic [PRIME_W-1:0] PRIME_MAX   = PRIME_W'(MAX_PRIME);

    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_DIAG = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_EMIT_ROW,
        ST_EMIT_DIAG
    } evo_state_t;

    typedef struct packed {
        logic             acc_en;
        logic [IDX_W-1:0] acc_row;
        logic             acc_to_adj;
        logic [IDX_W-1:0] acc_diag;
        logic             load;
        logic             load_kind;
        logic [IDX_W-1:0] load_idx;
        logic             load_last;
        logic             clear;
    } evo_cmd_t;

    typedef struct packed {
        logic out_free;
    } evo_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/evo_dp.sv
// datapath: row and diagonal parity stores, adjuster and output register
`timescale 1ns / 1ps
`default_nettype none
module evo_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire evo_pkg::evo_cmd_t             cmd,
    output evo_pkg::evo_status_t               status,
    input  wire logic [evo_pkg::BYTE_W-1:0]    data_byte,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [evo_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import evo_pkg::*;

    logic [BYTE_W-1:0] row_reg  [ROWS_MAX];
    logic [BYTE_W-1:0] diag_reg [ROWS_MAX];
    logic [BYTE_W-1:0] adj_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_kind_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] out_byte_next;

    assign status.out_free = !out_valid_reg || m_tready;

    // diagonal bytes leave with the adjuster folded in
    assign out_byte_next = cmd.load_kind ? (diag_reg[cmd.load_idx] ^ adj_reg)
                                         : row_reg[cmd.load_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < ROWS_MAX; i++) begin
                row_reg[i]  <= '0;
                diag_reg[i] <= '0;
            end
            adj_reg <= '0;
        end else if (cmd.acc_en) begin
            row_reg[cmd.acc_row] <= row_reg[cmd.acc_row] ^ data_byte;
            if (cmd.acc_to_adj) begin
                adj_reg <= adj_reg ^ data_byte;
            end else begin
                diag_reg[cmd.acc_diag] <= diag_reg[cmd.acc_diag] ^ data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_byte_reg <= out_byte_next;
            out_kind_reg <= cmd.load_kind;
            out_idx_reg  <= cmd.load_idx;
            out_last_reg <= cmd.load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_idx_reg, out_byte_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> hw/rtl/evo_ctrl.sv
// controller: prime register, stripe counters and parity readout sequencer
`timescale 1ns / 1ps
`default_nettype none
module evo_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [evo_pkg::PRIME_W-1:0]   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire evo_pkg::evo_status_t          status,
    output evo_pkg::evo_cmd_t                  cmd
);
    import evo_pkg::*;

    evo_state_t          state_reg, state_next;
    logic [PRIME_W-1:0]  prime_reg, prime_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PRIME_W-1:0]  p_eff;
    logic [IDX_W-1:0]    last_row;
    logic [COL_W-1:0]    last_col;
    logic [SUM_W-1:0]    diag_sum;
    logic [SUM_W-1:0]    diag_wrap;

    assign p_eff = (prime_reg < PRIME_MIN) ? PRIME_MIN :
                   (prime_reg > PRIME_MAX) ? PRIME_MAX : prime_reg;
    assign last_row  = IDX_W'(p_eff - PRIME_W'(2));
    assign last_col  = COL_W'(p_eff - PRIME_W'(1));
    assign diag_sum  = SUM_W'(col_reg) + SUM_W'(row_reg);
    assign diag_wrap = diag_sum - SUM_W'(p_eff);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            prime_reg <= PRIME_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            prime_reg <= prime_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        prime_next     = prime_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.acc_row    = row_reg;
        cmd.acc_to_adj = (diag_sum == SUM_W'(last_col));
        cmd.acc_diag   = (diag_sum < SUM_W'(last_col)) ? IDX_W'(diag_sum)
                                                        : IDX_W'(diag_wrap);
        cmd.load_idx   = idx_reg;

        if (cfg_valid) begin
            // new prime drops any stripe in progress
            prime_next = cfg_data;
            col_next   = '0;
            row_next   = '0;
            idx_next   = '0;
            state_next = ST_ACCUM;
            cmd.clear  = 1'b1;
        end else begin
            case (state_reg)
                ST_ACCUM: begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.acc_en = 1'b1;
                        if (row_reg == last_row) begin
                            row_next = '0;
                            if (col_reg == last_col) begin
                                col_next   = '0;
                                idx_next   = '0;
                                state_next = ST_EMIT_ROW;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end else begin
                            row_next = row_reg + IDX_W'(1);
                        end
                    end
                end
                ST_EMIT_ROW: begin
                    if (status.out_free) begin
                        cmd.load      = 1'b1;
                        cmd.load_kind = KIND_ROW;
                        if (idx_reg == last_row) begin
                            idx_next   = '0;
                            state_next = ST_EMIT_DIAG;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_EMIT_DIAG: begin
                    if (status.out_free) begin
                        cmd.load      = 1'b1;
                        cmd.load_kind = KIND_DIAG;
                        if (idx_reg == last_row) begin
                            // stores are read before this edge clears them
                            cmd.load_last = 1'b1;
                            cmd.clear     = 1'b1;
                            idx_next      = '0;
                            state_next    = ST_ACCUM;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_next = ST_ACCUM;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_load_while_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg != ST_ACCUM))
        else $error("parity beat loaded while accumulating");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_en |-> (row_reg <= last_row) && (col_reg <= last_col))
        else $error("stripe counter out of range");

    a_last_returns_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.load_last) |=> (state_reg == ST_ACCUM) && (col_reg == '0)
                                        && (row_reg == '0))
        else $error("stripe did not restart after last parity beat");

    a_last_is_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.load_last) |-> (cmd.load_kind == KIND_DIAG)
                                        && (cmd.load_idx == last_row))
        else $error("last flag on wrong parity beat");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/evenodd_parity_encoder_core.sv
// top level of the evenodd parity encoder: controller plus datapath
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata[7:0] data_byte
// m_       out  m_tvalid/m_tready    m_tdata[7:0] parity_byte, [11:8] row_index,
//                                    m_tuser parity_kind, m_tlast last
// cfg      in   cfg_valid/cfg_ready  cfg_data[4:0] prime_p
//
// data beats are taken one per cycle while no cfg write is pending, p*(p-1) per stripe, into flip-flop stores
// after the last data beat the readout emits 2*(p-1) parity beats,
// during which s_tready is low; m_tready low stalls the readout
// the next stripe's data is accepted while the final parity beat still waits
// reset (aresetn low, synchronous) sets p to 5 and clears all stripe state
`timescale 1ns / 1ps
`default_nettype none
module evenodd_parity_encoder_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [evo_pkg::PRIME_W-1:0]   cfg_data,   // prime_p
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [evo_pkg::S_TDATA_W-1:0] s_tdata,    // [7:0] data_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [evo_pkg::M_TDATA_W-1:0]      m_tdata,    // [7:0] parity_byte, [11:8] row_index
    output logic                               m_tuser,    // parity_kind
    output logic                               m_tlast
);
    import evo_pkg::*;

    evo_cmd_t    cmd;
    evo_status_t status;

    evo_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    evo_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .data_byte (s_tdata[BYTE_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the evenodd parity encoder core
`timescale 1ns / 1ps
module testbench;
    import evo_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 230;
    localparam int LONG_HOLD    = 200;
    localparam int DIR_STEPS    = 29;

    typedef enum logic {
        STEP_DATA,
        STEP_PRIME
    } step_kind_e;

    // typed_parity holds parity beat n in bits [8n+7:8n], used only for p = 3 stripes
    typedef struct packed {
        step_kind_e  kind;
        logic [7:0]  value;
        logic        typed;
        logic [31:0] typed_parity;
    } dir_step_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              kind;
        logic [3:0]        row_idx;
        logic              last;
    } parity_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [PRIME_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [7:0] data_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [7:0] parity_byte, [11:8] row_index
    logic                 m_tuser;     // parity_kind
    logic                 m_tlast;

    // encoder state as the testbench sees it
    logic [PRIME_W-1:0] prime_reg;
    logic [BYTE_W-1:0]  row_par [ROWS_MAX];
    logic [BYTE_W-1:0]  diag_par [ROWS_MAX];
    logic [BYTE_W-1:0]  adj_par;
    int                 col_cnt;
    int                 row_cnt;

    parity_beat_t parity_due_q [$];
    parity_beat_t seen_due;
    int           err_count = 0;
    int           cycle_count = 0;
    int           parity_beats_seen = 0;
    int           items_sent = 0;
    bit           tx_steady = 1'b0;

    dir_step_t dir_steps [DIR_STEPS] = '{
        // stripe at the reset prime of 5
        '{STEP_DATA, 8'h00, 1'b0, 32'h0}, '{STEP_DATA, 8'hFF, 1'b0, 32'h0},
        '{STEP_DATA, 8'h80, 1'b0, 32'h0}, '{STEP_DATA, 8'h01, 1'b0, 32'h0},
        '{STEP_DATA, 8'h55, 1'b0, 32'h0}, '{STEP_DATA, 8'hAA, 1'b0, 32'h0},
        '{STEP_DATA, 8'h7F, 1'b0, 32'h0}, '{STEP_DATA, 8'hFE, 1'b0, 32'h0},
        '{STEP_DATA, 8'h12, 1'b0, 32'h0}, '{STEP_DATA, 8'h34, 1'b0, 32'h0},
        '{STEP_DATA, 8'h56, 1'b0, 32'h0}, '{STEP_DATA, 8'h78, 1'b0, 32'h0},
        '{STEP_DATA, 8'h9A, 1'b0, 32'h0}, '{STEP_DATA, 8'hBC, 1'b0, 32'h0},
        '{STEP_DATA, 8'hDE, 1'b0, 32'h0}, '{STEP_DATA, 8'hF0, 1'b0, 32'h0},
        '{STEP_DATA, 8'h0F, 1'b0, 32'h0}, '{STEP_DATA, 8'hC3, 1'b0, 32'h0},
        '{STEP_DATA, 8'h3C, 1'b0, 32'h0}, '{STEP_DATA, 8'h5A, 1'b0, 32'h0},
        // prime below the floor acts as 3; all-ones stripe gives ones rows, zero diagonals
        '{STEP_PRIME, 8'h00, 1'b0, 32'h0},
        '{STEP_DATA, 8'hFF, 1'b0, 32'h0}, '{STEP_DATA, 8'hFF, 1'b0, 32'h0},
        '{STEP_DATA, 8'hFF, 1'b0, 32'h0}, '{STEP_DATA, 8'hFF, 1'b0, 32'h0},
        '{STEP_DATA, 8'hFF, 1'b0, 32'h0}, '{STEP_DATA, 8'hFF, 1'b1, 32'h0000FFFF},
        // prime above the ceiling, then a stripe left unfinished
        '{STEP_PRIME, 8'h1F, 1'b0, 32'h0},
        '{STEP_DATA, 8'hA5, 1'b0, 32'h0}
    };

    // mostly small primes, with out-of-range and non-prime values mixed in
    logic [PRIME_W-1:0] small_primes [16] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4,
        5'd5, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7, 5'd9, 5'd11
    };

    evenodd_parity_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic int active_prime();
        if (prime_reg < PRIME_MIN) begin
            return int'(PRIME_MIN);
        end
        if (prime_reg > PRIME_MAX) begin
            return MAX_PRIME;
        end
        return int'(prime_reg);
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_data_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 8'h00;
        end
        if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 40) begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
    endtask

    task automatic clear_stripe();
        int i;
        for (i = 0; i < ROWS_MAX; i++) begin
            row_par[i]  = '0;
            diag_par[i] = '0;
        end
        adj_par = '0;
        col_cnt = 0;
        row_cnt = 0;
    endtask

    // xor one data byte into the row and diagonal parities; queue the parity
    // column beats when it completes the stripe
    task automatic fold_data_byte(input logic [7:0] b, input logic typed,
                                  input logic [31:0] typed_parity);
        int p;
        int rows;
        int col;
        int row;
        int d;
        int i;
        parity_beat_t beat;
        p    = active_prime();
        rows = p - 1;
        col  = col_cnt;
        row  = row_cnt;
        if (row >= rows) begin
            row = 0;
        end
        if (col >= p) begin
            col = 0;
        end
        row_par[row] ^= b;
        d = col + row;
        if (d == p - 1) begin
            adj_par ^= b;
        end else if (d < p - 1) begin
            diag_par[d] ^= b;
        end else begin
            diag_par[d - p] ^= b;
        end
        row++;
        if (row == rows) begin
            row = 0;
            col++;
        end
        row_cnt = row;
        col_cnt = col;
        if (col < p) begin
            return;
        end
        for (i = 0; i < 2 * rows; i++) begin
            if (i < rows) begin
                beat.value   = row_par[i];
                beat.kind    = KIND_ROW;
                beat.row_idx = 4'(i);
            end else begin
                beat.value   = diag_par[i - rows] ^ adj_par;
                beat.kind    = KIND_DIAG;
                beat.row_idx = 4'(i - rows);
            end
            beat.last = (i == 2 * rows - 1);
            if (typed) begin
                beat.value = typed_parity[8 * i +: 8];
            end
            parity_due_q.push_back(beat);
        end
        clear_stripe();
    endtask

    // entered and left at a falling edge
    task automatic send_data_byte(input logic [7:0] b, input logic typed,
                                  input logic [31:0] typed_parity);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        fold_data_byte(b, typed, typed_parity);
        items_sent++;
        @(negedge aclk);
    endtask

    // only while idle: all parity beats out, then room for a partial stripe to settle
    task automatic write_prime(input logic [PRIME_W-1:0] v);
        s_tvalid <= 1'b0;
        while (parity_due_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        prime_reg = v;
        clear_stripe();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [PRIME_W-1:0] raw, input int stripes);
        int p;
        int n;
        write_prime(raw);
        p = active_prime();
        n = stripes * p * (p - 1);
        // now and then leave a stripe unfinished for the next write to drop
        if ($urandom_range(0, 3) == 0) begin
            n += $urandom_range(1, p * (p - 1) - 1);
        end
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            send_data_byte(random_data_byte(), 1'b0, 32'h0);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            parity_beats_seen++;
            if (parity_due_q.size() == 0) begin
                report_mismatch("parity beat with none due, tdata", m_tdata, 0);
            end else begin
                seen_due = parity_due_q.pop_front();
                if (m_tdata[7:0] != seen_due.value) begin
                    report_mismatch("parity_byte", m_tdata[7:0], seen_due.value);
                end
                if (m_tdata[11:8] != seen_due.row_idx) begin
                    report_mismatch("row_index", m_tdata[11:8], seen_due.row_idx);
                end
                if (m_tdata[15:12] != 4'h0) begin
                    report_mismatch("tdata pad bits", m_tdata[15:12], 0);
                end
                if (m_tuser != seen_due.kind) begin
                    report_mismatch("parity_kind", m_tuser, seen_due.kind);
                end
                if (m_tlast != seen_due.last) begin
                    report_mismatch("last", m_tlast, seen_due.last);
                end
            end
        end
    end

    // parity sink: random stalls, steady stretches, and one long hold-off
    // while data is offered so the input backs up
    initial begin
        int  gap;
        int  rx_run;
        bit  rx_steady;
        bit  long_hold_done;
        rx_run         = 0;
        rx_steady      = 1'b0;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        @(negedge aclk);
        forever begin
            if (rx_run == 0) begin
                rx_run    = $urandom_range(20, 80);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            rx_run--;
            if (!long_hold_done && parity_beats_seen >= 20 && m_tvalid && s_tvalid) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_done = 1'b1;
            end else begin
                gap = pick_gap(rx_steady);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin
        int k;
        int p;
        logic [PRIME_W-1:0] raw;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        prime_reg = PRIME_RESET;
        clear_stripe();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < DIR_STEPS; k++) begin
            if (dir_steps[k].kind == STEP_PRIME) begin
                write_prime(dir_steps[k].value[PRIME_W-1:0]);
            end else begin
                send_data_byte(dir_steps[k].value, dir_steps[k].typed,
                               dir_steps[k].typed_parity);
            end
        end

        // back-to-back small stripes first so the sink hold-off catches a busy input
        run_phase(PRIME_MIN, 3);
        while (items_sent < ITEM_TARGET) begin
            raw = small_primes[$urandom_range(0, 15)];
            prime_reg = raw;
            p = active_prime();
            run_phase(raw, (p <= 7) ? $urandom_range(1, 3) : 1);
        end

        s_tvalid <= 1'b0;
        while (parity_due_q.size() != 0) @(negedge aclk);
        repeat (2 * ROWS_MAX + 8) @(negedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/evo_pkg.sv
hw/rtl/evo_dp.sv
hw/rtl/evo_ctrl.sv
hw/rtl/evenodd_parity_encoder_core.sv
dv/testbench.sv
